// ----- hw/rtl/rgbhsv_pkg.sv -----
// Shared types and constants for the RGB to HSV converter.
// Used by every stage of the converter; depends on nothing.
package rgbhsv_pkg;

  localparam int ChW  = 8;
  localparam int HueW = 9;

  // Sector codes for the channel that holds the maximum.
  localparam logic [1:0] SEC_GREY  = 2'd0;
  localparam logic [1:0] SEC_RED   = 2'd1;
  localparam logic [1:0] SEC_GREEN = 2'd2;
  localparam logic [1:0] SEC_BLUE  = 2'd3;

  localparam logic [HueW-1:0] HUE_TURN     = 9'd360;
  localparam logic [HueW-1:0] HUE_OFFSET_G = 9'd120;
  localparam logic [HueW-1:0] HUE_OFFSET_B = 9'd240;

  // Number of divider cells, one quotient bit per cell.
  localparam int NumCells = ChW;

  // Word handed from stage to stage through the divider chain.
  typedef struct packed {
    logic [1:0]     sector;
    logic           hue_neg;
    logic [ChW-1:0] sat_rem;
    logic [ChW-1:0] sat_num;
    logic [ChW-1:0] sat_quo;
    logic [ChW-1:0] sat_div;
    logic [ChW-1:0] hue_rem;
    logic [ChW-1:0] hue_num;
    logic [ChW-1:0] hue_quo;
    logic [ChW-1:0] hue_div;
  } word_t;

endpackage

// ----- hw/rtl/rgb_to_hsv_converter.sv -----
// Top level of the 8-bit RGB to HSV converter.
// Depends on rgbhsv_pkg, rgbhsv_front, rgbhsv_cell and rgbhsv_back.
//
//   Channel | Handshake                 | Payload
//   --------+---------------------------+---------------------------------
//   pixel   | pixel_valid / pixel_stall | pixel_rgb (R 23:16, G 15:8, B 7:0)
//   hsv     | hsv_valid / hsv_stall     | hue, saturation, brightness
//
// One pixel word is taken every clock while pixel_stall is low. A result
// passes through one front stage, a chain of eight divider cells that each
// settle one quotient bit of saturation and of hue, and one output stage.
// Reset (rst, synchronous) clears only the stage valid bits.
// Every stage holds its word while the next one is full and stalled, so
// empty stages keep filling while hsv_stall is high; pixel_stall rises
// only once the whole chain is full.
module rgb_to_hsv_converter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pixel_valid,
  output logic                         pixel_stall,
  input  logic [23:0]                  pixel_rgb,
  output logic                         hsv_valid,
  input  logic                         hsv_stall,
  output logic [rgbhsv_pkg::HueW-1:0]  hue,
  output logic [rgbhsv_pkg::ChW-1:0]   saturation,
  output logic [rgbhsv_pkg::ChW-1:0]   brightness
);
  import rgbhsv_pkg::*;

  // Index 0 is the front stage output; index k is the output of cell k-1.
  logic  valid [NumCells+1];
  logic  stall [NumCells+1];
  word_t word  [NumCells+1];

  rgbhsv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel_valid),
    .in_stall  (pixel_stall),
    .pixel_rgb (pixel_rgb),
    .out_valid (valid[0]),
    .out_stall (stall[0]),
    .out_word  (word[0])
  );

  // The divider chain: each cell hands its partial remainders and
  // quotients to its neighbor every cycle that it is not stalled.
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    rgbhsv_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[k]),
      .in_stall  (stall[k]),
      .in_word   (word[k]),
      .out_valid (valid[k+1]),
      .out_stall (stall[k+1]),
      .out_word  (word[k+1])
    );
  end

  rgbhsv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (valid[NumCells]),
    .in_stall   (stall[NumCells]),
    .in_word    (word[NumCells]),
    .out_valid  (hsv_valid),
    .out_stall  (hsv_stall),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

  // Hue always lands inside one turn.
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> hue < HUE_TURN)
    else $error("hue out of range");

  // Saturation is zero only for grey pixels, and those carry zero hue.
  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && saturation == '0) |-> hue == '0)
    else $error("nonzero hue with zero saturation");

  // A black pixel is always grey.
  a_black: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && brightness == '0) |-> saturation == '0)
    else $error("saturation on a black pixel");

  // Back-pressure at the input only comes from a stalled, pending result.
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> (hsv_valid && hsv_stall))
    else $error("input stalled without output stall");

endmodule

// ----- hw/rtl/rgbhsv_front.sv -----
// Front stage: max, min, delta, sector and the two dividends.
// Depends on rgbhsv_pkg.
module rgbhsv_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [23:0]           pixel_rgb,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rgbhsv_pkg::word_t     out_word
);
  import rgbhsv_pkg::*;

  logic [ChW-1:0] r, g, b, mx, mn, delta, mag;
  logic [1:0]     sector;
  logic           neg;
  logic [15:0]    sat_dvd, hue_dvd;
  word_t          word_next;

  assign r = pixel_rgb[23:16];
  assign g = pixel_rgb[15:8];
  assign b = pixel_rgb[7:0];

  always_comb begin
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    // Ties for the maximum go to red, then green.
    if (delta == '0) begin
      sector = SEC_GREY;
      neg    = 1'b0;
      mag    = '0;
    end else if (r == mx) begin
      sector = SEC_RED;
      neg    = g < b;
      mag    = (g < b) ? (b - g) : (g - b);
    end else if (g == mx) begin
      sector = SEC_GREEN;
      neg    = b < r;
      mag    = (b < r) ? (r - b) : (b - r);
    end else begin
      sector = SEC_BLUE;
      neg    = r < g;
      mag    = (r < g) ? (g - r) : (r - g);
    end
  end

  // Both quotients fit in eight bits, so the upper dividend byte seeds the remainder.
  assign sat_dvd = {delta, 8'd0} - {8'd0, delta};
  assign hue_dvd = {2'd0, mag, 6'd0} - {6'd0, mag, 2'd0};

  always_comb begin
    word_next.sector  = sector;
    word_next.hue_neg = neg;
    word_next.sat_rem = sat_dvd[15:8];
    word_next.sat_num = sat_dvd[7:0];
    word_next.sat_quo = '0;
    word_next.sat_div = mx;
    word_next.hue_rem = hue_dvd[15:8];
    word_next.hue_num = hue_dvd[7:0];
    word_next.hue_quo = '0;
    word_next.hue_div = delta;
  end

  assign in_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      out_word <= word_next;
    end
  end

endmodule

// ----- hw/rtl/rgbhsv_cell.sv -----
// One divider cell: a restoring step for saturation and for hue.
// Depends on rgbhsv_pkg.
module rgbhsv_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  rgbhsv_pkg::word_t in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output rgbhsv_pkg::word_t out_word
);
  import rgbhsv_pkg::*;

  logic [ChW:0] sat_t, hue_t, sat_d, hue_d;
  logic         sat_ge, hue_ge;
  word_t        word_next;

  assign sat_t  = {in_word.sat_rem, in_word.sat_num[ChW-1]};
  assign hue_t  = {in_word.hue_rem, in_word.hue_num[ChW-1]};
  assign sat_ge = sat_t >= {1'b0, in_word.sat_div};
  assign hue_ge = hue_t >= {1'b0, in_word.hue_div};
  assign sat_d  = sat_ge ? (sat_t - {1'b0, in_word.sat_div}) : sat_t;
  assign hue_d  = hue_ge ? (hue_t - {1'b0, in_word.hue_div}) : hue_t;

  always_comb begin
    word_next         = in_word;
    word_next.sat_rem = sat_d[ChW-1:0];
    word_next.sat_num = {in_word.sat_num[ChW-2:0], 1'b0};
    word_next.sat_quo = {in_word.sat_quo[ChW-2:0], sat_ge};
    word_next.hue_rem = hue_d[ChW-1:0];
    word_next.hue_num = {in_word.hue_num[ChW-2:0], 1'b0};
    word_next.hue_quo = {in_word.hue_quo[ChW-2:0], hue_ge};
  end

  assign in_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      out_word <= word_next;
    end
  end

endmodule

// ----- hw/rtl/rgbhsv_back.sv -----
// Back stage: applies the hue sign and sector offset, registers the result.
// Depends on rgbhsv_pkg.
module rgbhsv_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rgbhsv_pkg::word_t                 in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rgbhsv_pkg::HueW-1:0]       hue,
  output logic [rgbhsv_pkg::ChW-1:0]        saturation,
  output logic [rgbhsv_pkg::ChW-1:0]        brightness
);
  import rgbhsv_pkg::*;

  logic [HueW-1:0] q, hue_next;
  logic [ChW-1:0]  sat_next;

  assign q = {1'b0, in_word.hue_quo};

  always_comb begin
    sat_next = in_word.sat_quo;
    case (in_word.sector)
      SEC_RED: begin
        // A negative quotient that truncated to zero wraps to zero, not a full turn.
        if (in_word.hue_neg && q != '0) hue_next = HUE_TURN - q;
        else hue_next = q;
      end
      SEC_GREEN: begin
        hue_next = in_word.hue_neg ? (HUE_OFFSET_G - q) : (HUE_OFFSET_G + q);
      end
      SEC_BLUE: begin
        hue_next = in_word.hue_neg ? (HUE_OFFSET_B - q) : (HUE_OFFSET_B + q);
      end
      default: begin
        hue_next = '0;
        sat_next = '0;
      end
    endcase
  end

  assign in_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      hue        <= hue_next;
      saturation <= sat_next;
      brightness <= in_word.sat_div;
    end
  end

endmodule
